@@ rtl/gww_pkg.sv @@
// Shared types and constants for the greedy word wrapper.
// Used by gww_front, gww_back and greedy_word_wrap_top; no dependencies.
package gww_pkg;

  // default sizes
  localparam int MAX_WORD_DEF = 32;
  localparam int LINE_CAP_DEF = 64;

  // separator codes
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_NL    = 8'd10;

  // configuration
  localparam int LW_W      = 6;
  localparam int LIM_W     = 7;
  localparam int CFG_W     = 7;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_LIMIT = 1'd1;

  localparam logic [LW_W-1:0]  LW_RESET  = 6'd10;
  localparam logic [LIM_W-1:0] LIM_RESET = 7'd64;

  // line state widths
  localparam int LL_W  = 6;
  localparam int LD_W  = 7;
  localparam int IDX_W = 6;

  // command queue depth between front and back
  localparam int Q_DEPTH = 2;

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       out_char;
    logic             char_valid;
    logic             line_break;
    logic [IDX_W-1:0] line_index;
    logic             word_truncated;
    logic             text_done;
    logic             last_of_run;
  } out_item_t;

  typedef enum logic [1:0] {
    OP_STORE = 2'd0,
    OP_SPACE = 2'd1,
    OP_NL    = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic       eot;
  } cmd_t;

  typedef struct packed {
    logic [LW_W-1:0]  line_width;
    logic [LIM_W-1:0] line_limit;
  } cfg_t;

endpackage

@@ rtl/gww_front.sv @@
// Front end: accepts input items, classifies them into commands and queues them.
// Depends on gww_pkg.
module gww_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  gww_pkg::in_item_t in_data,
  output logic              q_valid,
  output gww_pkg::cmd_t     q_cmd,
  input  logic              q_pop
);
  import gww_pkg::*;

  localparam int QA_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int QC_W = $clog2(Q_DEPTH + 1);

  cmd_t            q_mem [Q_DEPTH];
  logic [QA_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic            push;
  logic            pop;
  cmd_t            cmd_in;

  assign in_stall = (count_r == QC_W'(Q_DEPTH));
  assign q_valid  = (count_r != '0);
  assign q_cmd    = q_mem[rd_ptr_r];

  // an item with neither a character nor an end mark is dropped here
  assign push = in_valid && !in_stall && (in_data.has_char || in_data.end_of_text);
  assign pop  = q_pop && q_valid;

  always_comb begin
    cmd_in.char_code = in_data.char_code;
    cmd_in.eot       = in_data.end_of_text;
    if (!in_data.has_char) begin
      cmd_in.op = OP_FLUSH;
    end else begin
      case (in_data.char_code)
        CHAR_SPACE: cmd_in.op = OP_SPACE;
        CHAR_NL:    cmd_in.op = OP_NL;
        default:    cmd_in.op = OP_STORE;
      endcase
    end
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QC_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

@@ rtl/gww_back.sv @@
// Back end: word store, line placement sequencer, pending result and output register.
// Depends on gww_pkg; fed by gww_front through its command queue.
module gww_back #(
  parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF,
  parameter int LINE_CAP = gww_pkg::LINE_CAP_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  gww_pkg::cfg_t      cfg,
  input  logic               q_valid,
  input  gww_pkg::cmd_t      q_cmd,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output gww_pkg::out_item_t out_data
);
  import gww_pkg::*;

  localparam int WL_W   = $clog2(MAX_WORD + 1);
  localparam int WA_W   = $clog2(MAX_WORD);
  localparam int NEED_W = ((WL_W > LL_W) ? WL_W : LL_W) + 2;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_PLACE = 5'b00010,
    S_EMIT  = 5'b00100,
    S_TAIL  = 5'b01000,
    S_END   = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [WL_W-1:0] wl_r, wl_nxt;
  logic            ovf_r, ovf_nxt;
  logic [LL_W-1:0] ll_r, ll_nxt;
  logic [LD_W-1:0] ld_r, ld_nxt;
  logic [WL_W-1:0] idx_r, idx_nxt;
  logic            eot_r, eot_nxt;
  logic            nl_r, nl_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  out_item_t       pend_r, pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_r, out_nxt;

  logic [7:0]      word_mem [MAX_WORD];
  logic [7:0]      rdata_r;
  logic            mem_we;
  logic [WA_W-1:0] rd_addr;

  logic              can_push;
  logic              go;
  logic              emit_ok;
  logic              push;
  out_item_t         push_item;
  logic [NEED_W-1:0] need;
  logic              fits;
  logic [LL_W-1:0]   new_ll;

  function automatic out_item_t mk(input logic [7:0] ch, input logic vld,
                                   input logic brk, input logic trunc,
                                   input logic [LD_W-1:0] ld);
    out_item_t r;
    r.out_char       = ch;
    r.char_valid     = vld;
    r.line_break     = brk;
    r.line_index     = ld[IDX_W-1:0];
    r.word_truncated = trunc;
    r.text_done      = 1'b0;
    r.last_of_run    = 1'b0;
    return r;
  endfunction

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign can_push = !out_valid_r || !out_stall;
  // a new result may enter the pending slot once the old one can move on
  assign go       = !pend_valid_r || can_push;
  assign emit_ok  = (ld_r < cfg.line_limit) && (32'(ld_r) < LINE_CAP);

  assign need   = NEED_W'(ll_r) + NEED_W'(1) + NEED_W'(wl_r);
  assign fits   = (ll_r == '0) || (need <= NEED_W'(cfg.line_width));
  assign new_ll = (fits && (ll_r != '0)) ? need[LL_W-1:0] : LL_W'(wl_r);

  assign rd_addr = idx_nxt[WA_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    wl_nxt         = wl_r;
    ovf_nxt        = ovf_r;
    ll_nxt         = ll_r;
    ld_nxt         = ld_r;
    idx_nxt        = idx_r;
    eot_nxt        = eot_r;
    nl_nxt         = nl_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_nxt        = out_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    push           = 1'b0;
    push_item      = pend_r;

    case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          eot_nxt = q_cmd.eot;
          nl_nxt  = (q_cmd.op == OP_NL);
          case (q_cmd.op)
            OP_STORE: begin
              if (32'(wl_r) < MAX_WORD) begin
                mem_we = 1'b1;
                wl_nxt = wl_r + WL_W'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
              state_nxt = q_cmd.eot ? S_PLACE : S_IDLE;
            end
            OP_SPACE, OP_NL, OP_FLUSH: state_nxt = S_PLACE;
            default:                   state_nxt = S_IDLE;
          endcase
        end
      end

      S_PLACE: begin
        if (wl_r == '0) begin
          state_nxt = eot_r ? S_TAIL : S_END;
        end else begin
          idx_nxt = '0;
          ll_nxt  = new_ll;
          if (!fits) begin
            // word does not fit a non-empty line: close it first
            if (emit_ok) begin
              pend_nxt       = mk(8'd0, 1'b0, 1'b1, 1'b0, ld_r);
              pend_valid_nxt = 1'b1;
              ld_nxt         = ld_r + LD_W'(1);
            end
          end else if (ll_r != '0) begin
            if (emit_ok) begin
              pend_nxt       = mk(CHAR_SPACE, 1'b1, 1'b0, 1'b0, ld_r);
              pend_valid_nxt = 1'b1;
            end
          end
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (!emit_ok) begin
          state_nxt = S_TAIL;
        end else if (go) begin
          push           = pend_valid_r;
          pend_nxt       = mk(rdata_r, 1'b1, 1'b0, ovf_r, ld_r);
          pend_valid_nxt = 1'b1;
          idx_nxt        = idx_r + WL_W'(1);
          if ((idx_r + WL_W'(1)) == wl_r) begin
            state_nxt = S_TAIL;
          end
        end
      end

      S_TAIL: begin
        wl_nxt  = '0;
        ovf_nxt = 1'b0;
        if ((eot_r || nl_r) && (ll_r != '0)) begin
          if (!emit_ok) begin
            ll_nxt    = '0;
            state_nxt = S_END;
          end else if (pend_valid_r && pend_r.char_valid && !pend_r.line_break) begin
            // merge the close onto the character just placed
            pend_nxt.line_break = 1'b1;
            ld_nxt              = ld_r + LD_W'(1);
            ll_nxt              = '0;
            state_nxt           = S_END;
          end else if (go) begin
            push           = pend_valid_r;
            pend_nxt       = mk(8'd0, 1'b0, 1'b1, 1'b0, ld_r);
            pend_valid_nxt = 1'b1;
            ld_nxt         = ld_r + LD_W'(1);
            ll_nxt         = '0;
            state_nxt      = S_END;
          end
        end else begin
          state_nxt = S_END;
        end
      end

      S_END: begin
        if (pend_valid_r || eot_r) begin
          if (can_push) begin
            push      = 1'b1;
            push_item = pend_valid_r ? pend_r : mk(8'd0, 1'b0, 1'b0, 1'b0, ld_r);
            push_item.last_of_run = 1'b1;
            push_item.text_done   = eot_r;
            pend_valid_nxt = 1'b0;
            if (eot_r) begin
              wl_nxt  = '0;
              ovf_nxt = 1'b0;
              ll_nxt  = '0;
              ld_nxt  = '0;
            end
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (push) begin
      out_valid_nxt = 1'b1;
      out_nxt       = push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wl_r         <= '0;
      ovf_r        <= 1'b0;
      ll_r         <= '0;
      ld_r         <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wl_r         <= wl_nxt;
      ovf_r        <= ovf_nxt;
      ll_r         <= ll_nxt;
      ld_r         <= ld_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    eot_r  <= eot_nxt;
    nl_r   <= nl_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

  // word store: one write port, one registered read port following idx_nxt
  always_ff @(posedge clk) begin
    if (mem_we) begin
      word_mem[wl_r[WA_W-1:0]] <= q_cmd.char_code;
    end
    rdata_r <= word_mem[rd_addr];
  end

endmodule

@@ rtl/greedy_word_wrap_top.sv @@
// Greedy word wrapper top level: configuration registers, front end and back end.
// The command queue lets the front end take new items while the back end is still placing a word;
// a separator or end item replays the buffered word one character at a time, and output stalls
// hold that replay.
// Reset: rst_n synchronous, active low; clears control and line state, sets line_width 10
// and line_limit 64; the word store is not cleared.
module greedy_word_wrap_top #(
  parameter int MAX_WORD = gww_pkg::MAX_WORD_DEF,
  parameter int LINE_CAP = gww_pkg::LINE_CAP_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  gww_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output gww_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [gww_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gww_pkg::CFG_W-1:0]     cfg_wdata
);
  import gww_pkg::*;

  logic [LW_W-1:0]  line_width_r;
  logic [LIM_W-1:0] line_limit_r;
  cfg_t             cfg;
  logic             q_valid;
  cmd_t             q_cmd;
  logic             q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LW_RESET;
      line_limit_r <= LIM_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LINE_WIDTH: line_width_r <= cfg_wdata[LW_W-1:0];
        REG_LINE_LIMIT: line_limit_r <= cfg_wdata[LIM_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.line_width = line_width_r;
  assign cfg.line_limit = line_limit_r;

  gww_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop)
  );

  gww_back #(
    .MAX_WORD (MAX_WORD),
    .LINE_CAP (LINE_CAP)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/greedy_word_wrap_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for greedy_word_wrap_top: feeds texts a byte at a time, predicts the
// wrapped character and line-break stream in step, and checks every result transfer.
// Depends on gww_pkg and the greedy_word_wrap_top RTL only.
module greedy_word_wrap_top_tb;
  import gww_pkg::*;

  localparam int MAX_WORD      = MAX_WORD_DEF;
  localparam int LINE_CAP      = LINE_CAP_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int LONG_HOLD     = 300;
  localparam logic [7:0] LETTER_A = 8'h61;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  greedy_word_wrap_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // wrapper state as the bench sees it
  logic [7:0] word_buf [MAX_WORD];
  int         word_len;
  bit         word_ovf;
  int         line_len;
  int         lines_closed;
  int         fmt_width = LW_RESET;
  int         fmt_limit = LIM_RESET;
  out_item_t  run_q[$];
  out_item_t  wrapped_q[$];

  // traffic control and statistics
  bit idle_on = 1'b1;
  int rx_hold_req, rx_hold_left, rx_burst_left;
  int holds_done, cycle_count, bad_count;
  int items_sent, texts_sent, formats_used;
  int results_seen, breaks_seen, trunc_seen;

  function automatic int line_cap_now();
    return (fmt_limit < LINE_CAP) ? fmt_limit : LINE_CAP;
  endfunction

  function automatic void put_char(logic [7:0] ch, bit trunc);
    out_item_t r;
    if (lines_closed >= line_cap_now()) return;
    r = '0;
    r.out_char       = ch;
    r.char_valid     = 1'b1;
    r.line_index     = IDX_W'(lines_closed);
    r.word_truncated = trunc;
    run_q.push_back(r);
  endfunction

  function automatic void close_line();
    out_item_t r;
    int        n;
    n = run_q.size();
    if (lines_closed < line_cap_now()) begin
      // merge the break onto a plain character of this run where possible
      if (n > 0 && run_q[n-1].char_valid && !run_q[n-1].line_break) begin
        run_q[n-1].line_break = 1'b1;
      end else begin
        r = '0;
        r.line_break = 1'b1;
        r.line_index = IDX_W'(lines_closed);
        run_q.push_back(r);
      end
      lines_closed++;
    end
    line_len = 0;
  endfunction

  function automatic bit place_word();
    int need;
    bit trunc;
    if (word_len == 0) return 1'b0;
    trunc = word_ovf;
    need  = (line_len == 0) ? word_len : line_len + 1 + word_len;
    if (need > fmt_width) begin
      if (line_len > 0) close_line();
      need = word_len;
    end else if (line_len > 0) begin
      put_char(CHAR_SPACE, 1'b0);
    end
    for (int i = 0; i < word_len; i++) put_char(word_buf[i], trunc);
    line_len = need & 63;
    word_len = 0;
    word_ovf = 1'b0;
    return 1'b1;
  endfunction

  // work out the results one accepted item causes and queue them
  function automatic void wrap_predict(in_item_t it);
    out_item_t r;
    bit        placed;
    run_q.delete();
    if (it.has_char) begin
      if (it.char_code == CHAR_SPACE || it.char_code == CHAR_NL) begin
        placed = place_word();
        if (placed && it.char_code == CHAR_NL && line_len > 0) close_line();
      end else if (word_len < MAX_WORD) begin
        word_buf[word_len] = it.char_code;
        word_len++;
      end else begin
        word_ovf = 1'b1;
      end
    end
    if (it.end_of_text) begin
      placed = place_word();
      if (line_len > 0) close_line();
      if (run_q.size() == 0) begin
        r = '0;
        r.line_index = IDX_W'(lines_closed);
        run_q.push_back(r);
      end
      run_q[run_q.size()-1].text_done = 1'b1;
      word_len     = 0;
      word_ovf     = 1'b0;
      line_len     = 0;
      lines_closed = 0;
    end
    if (run_q.size() > 0) run_q[run_q.size()-1].last_of_run = 1'b1;
    foreach (run_q[i]) wrapped_q.push_back(run_q[i]);
  endfunction

  function automatic in_item_t make_item(logic [7:0] c, bit has, bit eot);
    in_item_t it;
    it.char_code   = c;
    it.has_char    = has;
    it.end_of_text = eot;
    return it;
  endfunction

  function automatic logic [7:0] word_byte();
    logic [7:0] c;
    if ($urandom_range(0, 3) != 0) return LETTER_A + 8'($urandom_range(0, 25));
    do c = 8'($urandom_range(0, 255)); while (c == CHAR_SPACE || c == CHAR_NL);
    return c;
  endfunction

  // offer one item, hold it until the transfer, then predict its results
  task automatic push_item(input in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 8)) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    wrap_predict(it);
    if (it.has_char || it.end_of_text) items_sent++;
  endtask

  // drop valid, wait for every expected result, then let the block go quiet
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (wrapped_q.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_format(input int width, input int limit);
    settle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_LINE_WIDTH;
    cfg_wdata <= CFG_W'(width);
    @(negedge clk);
    cfg_index <= REG_LINE_LIMIT;
    cfg_wdata <= CFG_W'(limit);
    @(negedge clk);
    cfg_we <= 1'b0;
    fmt_width = width;
    fmt_limit = limit;
    formats_used++;
  endtask

  // well-formed texts: words of random length, mixed separators, a random kind of ending
  task automatic send_texts(input int budget, input int long_pct);
    int sent, wlen;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(1, 8)) begin
        if (sent >= budget) break;
        if ($urandom_range(1, 100) <= long_pct) wlen = $urandom_range(MAX_WORD - 1, MAX_WORD + 4);
        else wlen = $urandom_range(0, 9);
        repeat (wlen) begin
          push_item(make_item(word_byte(), 1'b1, 1'b0));
          sent++;
        end
        case ($urandom_range(0, 9))
          6, 7: push_item(make_item(CHAR_NL, 1'b1, 1'b0));
          8: begin
            push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
            push_item(make_item(CHAR_NL, 1'b1, 1'b0));
            sent++;
          end
          9: begin
            push_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
            push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
          end
          default: push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
        endcase
        sent++;
      end
      case ($urandom_range(0, 2))
        0: push_item(make_item(8'($urandom_range(0, 255)), 1'b0, 1'b1));
        1: push_item(make_item(word_byte(), 1'b1, 1'b1));
        default: push_item(make_item($urandom_range(0, 1) ? CHAR_NL : CHAR_SPACE, 1'b1, 1'b1));
      endcase
      sent++;
      texts_sent++;
    end
  endtask

  task automatic test_directed_basics();
    // empty words, an ignored item and an end with nothing to flush
    push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
    push_item(make_item(CHAR_NL, 1'b1, 1'b0));
    push_item(make_item(8'h00, 1'b0, 1'b0));
    push_item(make_item(8'hFF, 1'b0, 1'b1));
    // "ab cd" fits, "efghij" wraps, newline closes
    push_item(make_item(8'h61, 1'b1, 1'b0));
    push_item(make_item(8'h62, 1'b1, 1'b0));
    push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
    push_item(make_item(8'h63, 1'b1, 1'b0));
    push_item(make_item(8'h64, 1'b1, 1'b0));
    push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
    for (int i = 0; i < 6; i++) push_item(make_item(8'h65 + 8'(i), 1'b1, 1'b0));
    push_item(make_item(CHAR_NL, 1'b1, 1'b0));
    // byte extremes, flushed by an end item that carries a character
    push_item(make_item(8'h00, 1'b1, 1'b0));
    push_item(make_item(8'hFF, 1'b1, 1'b0));
    push_item(make_item(8'h01, 1'b1, 1'b1));
    texts_sent += 2;
  endtask

  task automatic test_directed_extremes();
    // one-column lines and a one-line limit: oversized first word, then suppression
    set_format(1, 1);
    push_item(make_item(8'h61, 1'b1, 1'b0));
    push_item(make_item(8'h62, 1'b1, 1'b0));
    push_item(make_item(CHAR_SPACE, 1'b1, 1'b0));
    push_item(make_item(8'h63, 1'b1, 1'b0));
    push_item(make_item(8'h64, 1'b1, 1'b0));
    push_item(make_item(8'h00, 1'b0, 1'b1));
    texts_sent++;
  endtask

  task automatic test_wide_lines();
    set_format(32, 64);
    send_texts(25, 0);
  endtask

  task automatic test_narrow_lines();
    set_format(1, 64);
    send_texts(20, 0);
  endtask

  task automatic test_line_limit();
    set_format($urandom_range(3, 12), $urandom_range(1, 4));
    send_texts(25, 0);
  endtask

  task automatic test_long_words();
    set_format(8, 64);
    send_texts(30, 30);
  endtask

  // unstructured bytes, separators, bare end items and ignored items
  task automatic test_noise();
    in_item_t it;
    int       sent;
    set_format($urandom_range(1, 32), $urandom_range(1, 64));
    sent = 0;
    while (sent < 15) begin
      case ($urandom_range(0, 3))
        0: it.char_code = CHAR_SPACE;
        1: it.char_code = CHAR_NL;
        default: it.char_code = 8'($urandom_range(0, 255));
      endcase
      it.has_char    = ($urandom_range(0, 4) != 0);
      it.end_of_text = ($urandom_range(0, 11) == 0);
      push_item(it);
      if (it.has_char || it.end_of_text) sent++;
    end
    push_item(make_item(8'h00, 1'b0, 1'b1));
    texts_sent++;
  endtask

  task automatic test_backpressure();
    set_format(10, 64);
    rx_hold_req = LONG_HOLD;
    send_texts(20, 10);
  endtask

  task automatic test_steady_stream();
    idle_on = 1'b0;
    set_format($urandom_range(1, 32), $urandom_range(1, 64));
    send_texts(15, 5);
  endtask

  task automatic report_mismatch(input string what, input out_item_t want, input out_item_t got);
    bad_count++;
    if (bad_count <= 10) begin
      $display("[%0t] %s: expected ch=%02h v=%b br=%b idx=%0d tr=%b done=%b last=%b",
               $time, what, want.out_char, want.char_valid, want.line_break, want.line_index,
               want.word_truncated, want.text_done, want.last_of_run);
      $display("    got ch=%02h v=%b br=%b idx=%0d tr=%b done=%b last=%b",
               got.out_char, got.char_valid, got.line_break, got.line_index,
               got.word_truncated, got.text_done, got.last_of_run);
    end
  endtask

  // check every result transfer against the oldest prediction
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n === 1'b1 && out_valid && !out_stall) begin
      results_seen++;
      if (out_data.line_break) breaks_seen++;
      if (out_data.word_truncated) trunc_seen++;
      if (wrapped_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data);
      end else begin
        want = wrapped_q.pop_front();
        if (out_data.out_char !== want.out_char || out_data.char_valid !== want.char_valid ||
            out_data.line_break !== want.line_break ||
            out_data.line_index !== want.line_index ||
            out_data.word_truncated !== want.word_truncated ||
            out_data.text_done !== want.text_done ||
            out_data.last_of_run !== want.last_of_run)
          report_mismatch("result mismatch", want, out_data);
      end
    end
  end

  // receiver: long hold on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
      holds_done++;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_stall <= 1'b1;
    end else if (rx_burst_left > 0) begin
      rx_burst_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      rx_burst_left = $urandom_range(0, 7);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycle_count, wrapped_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = REG_LINE_WIDTH;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_directed_basics();
    test_directed_extremes();
    test_wide_lines();
    test_narrow_lines();
    test_line_limit();
    test_long_words();
    test_noise();
    test_backpressure();
    test_steady_stream();
    settle();

    if (wrapped_q.size() > 0) begin
      bad_count += wrapped_q.size();
      $display("%0d predicted results never arrived", wrapped_q.size());
    end
    $display("Fed %0d items in %0d texts under %0d line formats, %0d long receiver hold(s).",
             items_sent, texts_sent, formats_used, holds_done);
    $display("Checked %0d results: %0d line breaks, %0d from truncated words; %0d mismatches.",
             results_seen, breaks_seen, trunc_seen, bad_count);
    if (bad_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
